### sv/pdmcc_pkg.sv
// Shared types and constants for the pot deadzone to MIDI CC block.
// Used by every module of the block; depends on nothing.
package pdmcc_pkg;

    localparam int ADC_BITS    = 10;
    localparam int POT_COUNT   = 3;
    localparam int SAMPLE_W    = 10;
    localparam int MIDI_W      = 7;
    localparam int TIME_W      = 32;
    localparam int POLL_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_CC     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_CC     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESONANCE_CC  = 3'd4;

    localparam logic [POLL_W-1:0]   POLL_RESET         = 16'd10;
    localparam logic [SAMPLE_W-1:0] DEADZONE_RESET     = 10'd8;
    localparam logic [MIDI_W-1:0]   VOLUME_CC_RESET    = 7'd7;
    localparam logic [MIDI_W-1:0]   CUTOFF_CC_RESET    = 7'd74;
    localparam logic [MIDI_W-1:0]   RESONANCE_CC_RESET = 7'd71;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] volume_sample;
        logic [SAMPLE_W-1:0] cutoff_sample;
        logic [SAMPLE_W-1:0] resonance_sample;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        pot_index;
        logic [MIDI_W-1:0] cc_number;
        logic [MIDI_W-1:0] cc_value;
        logic              last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [POLL_W-1:0]                  poll_interval_ms;
        logic [SAMPLE_W-1:0]                deadzone;
        logic [POT_COUNT-1:0][MIDI_W-1:0]   cc_number;
    } cfg_t;

    typedef struct packed {
        logic [POT_COUNT-1:0]               emit;
        logic [POT_COUNT-1:0][MIDI_W-1:0]   midi;
    } job_t;

endpackage

### sv/pdmcc_front.sv
// Front end: poll interval check, deadzone filter and 7-bit mapping per pot.
// Pushes one job word per accepted sample set that changes a MIDI value.
// Depends on pdmcc_pkg.
module pdmcc_front #(
    parameter int ADC_BITS = pdmcc_pkg::ADC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pdmcc_pkg::in_word_t  in_word,
    input  pdmcc_pkg::cfg_t      cfg,
    input  logic                 q_full,
    output logic                 push,
    output pdmcc_pkg::job_t      job
);

    localparam int SW = pdmcc_pkg::SAMPLE_W;
    localparam int MW = pdmcc_pkg::MIDI_W;
    localparam int PN = pdmcc_pkg::POT_COUNT;
    localparam int PW = SW + MW + 1;
    localparam logic [PW-1:0] ADC_MAX     = PW'((18'd1 << ADC_BITS) - 18'd1);
    localparam logic [SW-1:0] SAMPLE_MASK = SW'((18'd1 << ADC_BITS) - 18'd1);

    logic [pdmcc_pkg::TIME_W-1:0] last_time_reg, last_time_next;
    logic [PN-1:0][SW-1:0]        raw_reg, raw_next;
    logic [PN-1:0][MW-1:0]        midi_reg, midi_next;

    logic [pdmcc_pkg::TIME_W-1:0] elapsed;
    logic                         take;
    logic [PN-1:0][SW-1:0]        sample;
    logic [PN-1:0][SW-1:0]        diff;
    logic [PN-1:0][PW-1:0]        prod;
    logic [PN-1:0][PW-1:0]        q0;
    logic [PN-1:0][PW-1:0]        rem;
    logic [PN-1:0][PW-1:0]        quot;
    logic [PN-1:0][MW-1:0]        midi;
    logic [PN-1:0]                moved;
    logic [PN-1:0]                emit;

    assign in_ready = !q_full;
    assign elapsed  = in_word.now_ms - last_time_reg;
    assign take     = in_valid && in_ready
                   && (elapsed >= {16'd0, cfg.poll_interval_ms});

    always_comb
    begin
        sample[0] = in_word.volume_sample & SAMPLE_MASK;
        sample[1] = in_word.cutoff_sample & SAMPLE_MASK;
        sample[2] = in_word.resonance_sample & SAMPLE_MASK;
        for (int k = 0; k < PN; k++)
        begin
            diff[k]  = (sample[k] > raw_reg[k]) ? sample[k] - raw_reg[k]
                                                : raw_reg[k] - sample[k];
            moved[k] = diff[k] > cfg.deadzone;
            // divide by 2^B-1: estimate, then one correction step
            prod[k]  = {1'b0, sample[k], 7'd0} - PW'(sample[k]);
            q0[k]    = (prod[k] + (prod[k] >> ADC_BITS)) >> ADC_BITS;
            rem[k]   = prod[k] - ((q0[k] << ADC_BITS) - q0[k]);
            quot[k]  = (rem[k] >= ADC_MAX) ? q0[k] + PW'(1) : q0[k];
            midi[k]  = quot[k][MW-1:0];
            emit[k]  = moved[k] && (midi[k] != midi_reg[k]);
        end
    end

    always_comb
    begin
        last_time_next = last_time_reg;
        raw_next       = raw_reg;
        midi_next      = midi_reg;
        if (take)
        begin
            last_time_next = in_word.now_ms;
            for (int k = 0; k < PN; k++)
            begin
                if (moved[k])
                begin
                    raw_next[k] = sample[k];
                end
                if (emit[k])
                begin
                    midi_next[k] = midi[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            raw_reg       <= '0;
            midi_reg      <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
            raw_reg       <= raw_next;
            midi_reg      <= midi_next;
        end
    end

    assign push     = take && (|emit);
    assign job.emit = emit;
    assign job.midi = midi;

endmodule

### sv/pdmcc_queue.sv
// Short job queue between the front end and the message serializer.
// Depends on pdmcc_pkg.
module pdmcc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pdmcc_pkg::job_t  push_job,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output pdmcc_pkg::job_t  head_job
);

    localparam int DEPTH = pdmcc_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pdmcc_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/pdmcc_back.sv
// Back end: serializes each job into CC message words, lowest pot first.
// Holds one output register. Depends on pdmcc_pkg.
module pdmcc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  pdmcc_pkg::job_t      head_job,
    input  pdmcc_pkg::cfg_t      cfg,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pdmcc_pkg::out_word_t out_word
);

    localparam int PN = pdmcc_pkg::POT_COUNT;

    logic [PN-1:0]        done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;
    pdmcc_pkg::out_word_t out_word_reg, out_word_next;

    logic [PN-1:0] remaining;
    logic [PN-1:0] pick;
    logic [PN-1:0] rest;
    logic [1:0]    idx;
    logic          load;

    assign remaining = head_job.emit & ~done_reg;
    assign load      = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (remaining[0])
        begin
            idx = 2'd0;
        end
        else if (remaining[1])
        begin
            idx = 2'd1;
        end
        else
        begin
            idx = 2'd2;
        end
        pick = PN'(1) << idx;
        rest = remaining & ~pick;
    end

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next            = 1'b1;
            out_word_next.pot_index   = idx;
            out_word_next.cc_number   = cfg.cc_number[idx];
            out_word_next.cc_value    = head_job.midi[idx];
            out_word_next.last_of_run = (rest == '0);
            if (rest == '0)
            begin
                pop       = 1'b1;
                done_next = '0;
            end
            else
            begin
                done_next = done_reg | pick;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### sv/pot_deadzone_to_midi_cc_top.sv
// Top level of the pot deadzone to MIDI CC block: config registers,
// front end, job queue and message serializer.
// Depends on pdmcc_pkg, pdmcc_front, pdmcc_queue, pdmcc_back.
//
//   channel   signals                         word
//   input     in_valid / in_ready             in_word  (pdmcc_pkg::in_word_t)
//   output    out_valid / out_ready           out_word (pdmcc_pkg::out_word_t)
//   config    cfg_we, cfg_index               cfg_wdata (no read-back)
//
// The front end takes one sample set per cycle while the job queue is not full
// and updates its state in that cycle. Each set yields 0 to 3 messages; the
// serializer sends one per cycle from its output register while out_ready is high.
// Reset clears stored time, raw and MIDI values at once; no clearing pass.
// in_ready drops only while the two-entry job queue is full.
module pot_deadzone_to_midi_cc_top #(
    parameter int ADC_BITS = pdmcc_pkg::ADC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdmcc_pkg::in_word_t                 in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pdmcc_pkg::out_word_t                out_word,
    input  logic                                cfg_we,
    input  logic [pdmcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pdmcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pdmcc_pkg::cfg_t cfg_reg, cfg_next;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_head_valid;
    pdmcc_pkg::job_t q_push_job;
    pdmcc_pkg::job_t q_head_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdmcc_pkg::CFG_POLL_INTERVAL: cfg_next.poll_interval_ms = cfg_wdata;
                pdmcc_pkg::CFG_DEADZONE:      cfg_next.deadzone = cfg_wdata[9:0];
                pdmcc_pkg::CFG_VOLUME_CC:     cfg_next.cc_number[0] = cfg_wdata[6:0];
                pdmcc_pkg::CFG_CUTOFF_CC:     cfg_next.cc_number[1] = cfg_wdata[6:0];
                pdmcc_pkg::CFG_RESONANCE_CC:  cfg_next.cc_number[2] = cfg_wdata[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval_ms <= pdmcc_pkg::POLL_RESET;
            cfg_reg.deadzone         <= pdmcc_pkg::DEADZONE_RESET;
            cfg_reg.cc_number[0]     <= pdmcc_pkg::VOLUME_CC_RESET;
            cfg_reg.cc_number[1]     <= pdmcc_pkg::CUTOFF_CC_RESET;
            cfg_reg.cc_number[2]     <= pdmcc_pkg::RESONANCE_CC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pdmcc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (q_push),
        .job      (q_push_job)
    );

    pdmcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    pdmcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .cfg        (cfg_reg),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_word.last_of_run)
        |=> (out_valid && (out_word.pot_index > $past(out_word.pot_index))))
        else $error("run did not continue with a higher pot");

    a_pot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.pot_index != 2'd3))
        else $error("pot index out of range");

    a_last_pot_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.pot_index == 2'd2)) |-> out_word.last_of_run)
        else $error("resonance message not marked last");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pot_deadzone_to_midi_cc_top: random and directed sample sets,
// predicted CC messages compared word by word against the output channel.
// Depends on pdmcc_pkg and the block's RTL.
module tb_top;

    localparam int ADC_TOP      = (1 << pdmcc_pkg::ADC_BITS) - 1;
    localparam int MIDI_TOP     = 127;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TIME_W       = pdmcc_pkg::TIME_W;
    localparam int SAMPLE_W     = pdmcc_pkg::SAMPLE_W;
    localparam int MIDI_W       = pdmcc_pkg::MIDI_W;
    localparam int POLL_W       = pdmcc_pkg::POLL_W;
    localparam int POT_COUNT    = pdmcc_pkg::POT_COUNT;
    localparam int CFG_INDEX_W  = pdmcc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = pdmcc_pkg::CFG_DATA_W;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    pdmcc_pkg::in_word_t    in_word = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    pdmcc_pkg::out_word_t   out_word;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor state and its copy of the registers
    logic [TIME_W-1:0]   seen_time;
    logic [SAMPLE_W-1:0] held_raw [POT_COUNT];
    logic [MIDI_W-1:0]   held_midi [POT_COUNT];
    logic [POLL_W-1:0]   poll_ms;
    logic [SAMPLE_W-1:0] dead_band;
    logic [MIDI_W-1:0]   cc_map [POT_COUNT];

    pdmcc_pkg::in_word_t  sample_sets [$];
    pdmcc_pkg::out_word_t cc_expected [$];

    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    logic [TIME_W-1:0] gen_now;
    int gen_level [POT_COUNT];

    pot_deadzone_to_midi_cc_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic predict_cc(input pdmcc_pkg::in_word_t w);
        logic [SAMPLE_W-1:0]  smp [POT_COUNT];
        logic [TIME_W-1:0]    elapsed;
        logic [MIDI_W-1:0]    mv;
        pdmcc_pkg::out_word_t msg [POT_COUNT];
        int                   n;
        int                   delta;
        int                   k;
        smp[0] = w.volume_sample;
        smp[1] = w.cutoff_sample;
        smp[2] = w.resonance_sample;
        n = 0;
        elapsed = w.now_ms - seen_time;
        if (elapsed < TIME_W'(poll_ms))
            return;
        seen_time = w.now_ms;
        for (k = 0; k < POT_COUNT; k++)
        begin
            smp[k] = smp[k] & SAMPLE_W'(ADC_TOP);
            delta = (smp[k] > held_raw[k]) ? int'(smp[k]) - int'(held_raw[k])
                                           : int'(held_raw[k]) - int'(smp[k]);
            if (delta > int'(dead_band))
            begin
                mv = MIDI_W'((int'(smp[k]) * MIDI_TOP) / ADC_TOP);
                held_raw[k] = smp[k];
                if (mv != held_midi[k])
                begin
                    held_midi[k] = mv;
                    msg[n].pot_index   = 2'(k);
                    msg[n].cc_number   = cc_map[k];
                    msg[n].cc_value    = mv;
                    msg[n].last_of_run = 1'b0;
                    n = n + 1;
                end
            end
        end
        for (k = 0; k < n; k++)
        begin
            msg[k].last_of_run = (k == n - 1);
            cc_expected.push_back(msg[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_cc(in_word);
            if (!in_valid || in_ready)
            begin
                if (sample_sets.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_word  <= sample_sets.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (cc_expected.size() == 0)
                begin
                    $error("unexpected CC word: pot %0d cc %0d value %0d",
                           out_word.pot_index, out_word.cc_number, out_word.cc_value);
                    mismatches++;
                end
                else
                begin
                    pdmcc_pkg::out_word_t want;
                    want = cc_expected.pop_front();
                    if (out_word.pot_index !== want.pot_index)
                    begin
                        $error("pot_index: expected %0d, actual %0d",
                               want.pot_index, out_word.pot_index);
                        mismatches++;
                    end
                    if (out_word.cc_number !== want.cc_number)
                    begin
                        $error("cc_number: expected %0d, actual %0d",
                               want.cc_number, out_word.cc_number);
                        mismatches++;
                    end
                    if (out_word.cc_value !== want.cc_value)
                    begin
                        $error("cc_value: expected %0d, actual %0d",
                               want.cc_value, out_word.cc_value);
                        mismatches++;
                    end
                    if (out_word.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last_of_run, out_word.last_of_run);
                        mismatches++;
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            pdmcc_pkg::CFG_POLL_INTERVAL: poll_ms   = data;
            pdmcc_pkg::CFG_DEADZONE:      dead_band = data[SAMPLE_W-1:0];
            pdmcc_pkg::CFG_VOLUME_CC:     cc_map[0] = data[MIDI_W-1:0];
            pdmcc_pkg::CFG_CUTOFF_CC:     cc_map[1] = data[MIDI_W-1:0];
            pdmcc_pkg::CFG_RESONANCE_CC:  cc_map[2] = data[MIDI_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_set(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] vol,
                            input logic [SAMPLE_W-1:0] cut, input logic [SAMPLE_W-1:0] res);
        pdmcc_pkg::in_word_t w;
        w.now_ms           = now;
        w.volume_sample    = vol;
        w.cutoff_sample    = cut;
        w.resonance_sample = res;
        sample_sets.push_back(w);
    endtask

    task automatic wait_idle();
        while (sample_sets.size() != 0 || in_valid || cc_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly on-time sets with pots drifting; some early, some jumps, some wild samples
    task automatic add_random_set();
        logic [TIME_W-1:0] gap;
        logic [SAMPLE_W-1:0] smp [POT_COUNT];
        bit early;
        int pick;
        int span;
        int v;
        int k;
        pick  = $urandom_range(99);
        early = 1'b0;
        gap   = TIME_W'(poll_ms) + $urandom_range(3, 0);
        if (pick < 10 && poll_ms != 0)
        begin
            gap   = $urandom_range(int'(poll_ms) - 1, 0);
            early = 1'b1;
        end
        else if (pick < 14)
        begin
            gap = $urandom;
        end
        span = int'(dead_band) * 2 + 24;
        for (k = 0; k < POT_COUNT; k++)
        begin
            if (pick >= 14 && pick < 30)
                v = $urandom_range(1023, 0);
            else
                v = gen_level[k] + int'($urandom_range(2 * span, 0)) - span;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            smp[k] = SAMPLE_W'(v);
            if (!early)
                gen_level[k] = v;
        end
        push_set(gen_now + gap, smp[0], smp[1], smp[2]);
        if (!early)
            gen_now = gen_now + gap;
    endtask

    task automatic run_phase(input int count, input int snd, input int rcv, input bit long_hold);
        int k;
        @(negedge clk);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        gen_now = seen_time;
        for (k = 0; k < POT_COUNT; k++)
            gen_level[k] = int'(held_raw[k]);
        if (long_hold)
            hold_req = hold_req + 1;
        for (k = 0; k < count / 2; k++)
            add_random_set();
        wait_idle();
        for (k = count / 2; k < count; k++)
            add_random_set();
        wait_idle();
    endtask

    initial
    begin
        int k;
        seen_time = '0;
        for (k = 0; k < POT_COUNT; k++)
        begin
            held_raw[k]  = '0;
            held_midi[k] = '0;
        end
        poll_ms   = pdmcc_pkg::POLL_RESET;
        dead_band = pdmcc_pkg::DEADZONE_RESET;
        cc_map[0] = pdmcc_pkg::VOLUME_CC_RESET;
        cc_map[1] = pdmcc_pkg::CUTOFF_CC_RESET;
        cc_map[2] = pdmcc_pkg::RESONANCE_CC_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: start-up rejection, deadzone edges, time wrap
        push_set(32'd5,           10'd1023, 10'd1023, 10'd1023);
        push_set(32'd10,          10'd1023, 10'd1023, 10'd1023);
        push_set(32'd15,          10'd0,    10'd0,    10'd0);
        push_set(32'd20,          10'd1020, 10'd1016, 10'd1015);
        push_set(32'd30,          10'd0,    10'd1023, 10'd0);
        push_set(32'd40,          10'd9,    10'd1023, 10'd8);
        push_set(32'hFFFF_FFF0,   10'd512,  10'd256,  10'd768);
        push_set(32'h0000_0003,   10'd512,  10'd256,  10'd768);
        push_set(32'h0000_0005,   10'd0,    10'd0,    10'd0);
        push_set(32'h0000_000D,   10'h2AA,  10'h155,  10'h3FF);
        wait_idle();

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, 16'h0000);
        set_reg(pdmcc_pkg::CFG_DEADZONE,      16'hFC00);
        set_reg(pdmcc_pkg::CFG_VOLUME_CC,     16'hFF80);
        set_reg(pdmcc_pkg::CFG_CUTOFF_CC,     16'hFFFF);
        set_reg(pdmcc_pkg::CFG_RESONANCE_CC,  16'd85);
        for (k = int'(pdmcc_pkg::CFG_RESONANCE_CC) + 1; k < (1 << CFG_INDEX_W); k++)
            set_reg(CFG_INDEX_W'(k), 16'hFFFF);
        @(negedge clk);

        // zero interval and zero deadzone: raw moves while MIDI value holds
        push_set(32'd13,          10'd1,    10'd0,    10'd0);
        push_set(32'd13,          10'd5,    10'd0,    10'd8);
        push_set(32'd14,          10'd4,    10'd1023, 10'd0);
        push_set(32'hFFFF_FFFF,   10'd1023, 10'd1023, 10'd1023);
        wait_idle();

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, 16'hFFFF);
        set_reg(pdmcc_pkg::CFG_DEADZONE,      16'd1023);
        @(negedge clk);
        push_set(32'h0000_FFFD,   10'd0,    10'd0,    10'd0);
        push_set(32'h0000_FFFE,   10'd0,    10'd0,    10'd0);
        wait_idle();

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, pdmcc_pkg::POLL_RESET);
        set_reg(pdmcc_pkg::CFG_DEADZONE,      16'(pdmcc_pkg::DEADZONE_RESET));
        set_reg(pdmcc_pkg::CFG_VOLUME_CC,     16'(pdmcc_pkg::VOLUME_CC_RESET));
        set_reg(pdmcc_pkg::CFG_CUTOFF_CC,     16'(pdmcc_pkg::CUTOFF_CC_RESET));
        set_reg(pdmcc_pkg::CFG_RESONANCE_CC,  16'(pdmcc_pkg::RESONANCE_CC_RESET));
        run_phase(100, 13, 51, 1'b0);

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, 16'd0);
        set_reg(pdmcc_pkg::CFG_DEADZONE,      16'd0);
        set_reg(pdmcc_pkg::CFG_VOLUME_CC,     16'd0);
        set_reg(pdmcc_pkg::CFG_CUTOFF_CC,     16'd127);
        set_reg(pdmcc_pkg::CFG_RESONANCE_CC,  16'd85);
        run_phase(100, 51, 13, 1'b1);

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, 16'hFFFF);
        set_reg(pdmcc_pkg::CFG_DEADZONE,      16'd5);
        set_reg(pdmcc_pkg::CFG_VOLUME_CC,     CFG_DATA_W'($urandom));
        run_phase(30, 51, 13, 1'b0);

        set_reg(pdmcc_pkg::CFG_POLL_INTERVAL, CFG_DATA_W'($urandom_range(300, 0)));
        set_reg(pdmcc_pkg::CFG_DEADZONE,      CFG_DATA_W'($urandom_range(40, 1)));
        set_reg(pdmcc_pkg::CFG_VOLUME_CC,     CFG_DATA_W'($urandom));
        set_reg(pdmcc_pkg::CFG_CUTOFF_CC,     CFG_DATA_W'($urandom));
        set_reg(pdmcc_pkg::CFG_RESONANCE_CC,  CFG_DATA_W'($urandom));
        run_phase(90, 0, 0, 1'b0);

        if (cc_expected.size() != 0)
        begin
            $error("%0d CC words never arrived", cc_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
sv/pdmcc_pkg.sv
sv/pdmcc_front.sv
sv/pdmcc_queue.sv
sv/pdmcc_back.sv
sv/pot_deadzone_to_midi_cc_top.sv
tb/sv/tb_top.sv
